>>> sv/epg_pkg.sv
// Shared types and constants for the epicycloid point generator.
// No dependencies; used by epg_ratio_div, epg_sincos and the top level.
package epg_pkg;

    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int PHASE_FRAC_BITS_DEF = 16;

    localparam int ANGLE_W   = 32;
    localparam int RADIUS_W  = 16;
    localparam int COORD_W   = 20;
    localparam int RATIO_FRAC = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [RADIUS_W-1:0] RADIUS_BIG_RST   = 16'd512;
    localparam logic [RADIUS_W-1:0] RADIUS_SMALL_RST = 16'd256;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_BIG   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SMALL = 1'd1;

    // (R+r) << 16 plus r/2 fits in 33 bits
    localparam int DVD_W      = RADIUS_W + 1 + RATIO_FRAC;
    localparam int DIV_STAGES = DVD_W;

    localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;

    localparam int COS_STEPS = 8;
    localparam int SIN_STEPS = 7;
    // phase reduce, angle scale, square, series steps, quadrant map
    localparam int SC_LAT = 3 + 2 * COS_STEPS + 1;

    localparam logic [COORD_W-1:0] OUT_MAX = 20'h7FFFF;
    localparam logic [COORD_W-1:0] OUT_MIN = 20'h80000;

    typedef struct packed {
        logic [ANGLE_W-1:0]  angle;
        logic [RADIUS_W:0]   rsum;
        logic [RADIUS_W-1:0] rsmall;
        logic                err;
    } t_item;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } t_sc_ctl;

endpackage

>>> sv/epg_ratio_div.sv
// Pipelined restoring divider for the ratio q = ((R+r) << 16 + r/2) / r.
// One quotient bit per stage; uses epg_pkg.
module epg_ratio_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [epg_pkg::DVD_W-1:0]     i_dividend,
    input  logic [epg_pkg::RADIUS_W-1:0]  i_divisor,
    output logic [31:0]                   o_quot
);
    localparam int N  = epg_pkg::DVD_W;
    localparam int RW = epg_pkg::RADIUS_W;

    logic [RW-1:0] r_rem [N-1];
    logic [N-1:0]  r_dvd [N-1];
    logic [RW-1:0] r_dsr [N-1];
    logic [31:0]   r_quo [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [RW-1:0] dsr_in;
        logic [N-1:0]  dvd_in;
        logic [31:0]   quo_in;
        logic [RW:0]   trial;
        logic          take;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign dsr_in = i_divisor;
            assign dvd_in = i_dividend;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign dsr_in = r_dsr[j-1];
            assign dvd_in = r_dvd[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign trial = {rem_in, dvd_in[N-1]};
        assign take  = trial >= {1'b0, dsr_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= {quo_in[30:0], take};
            end
        end

        if (j < N - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= take ? RW'(trial - {1'b0, dsr_in}) : trial[RW-1:0];
                    r_dvd[j] <= dvd_in << 1;
                    r_dsr[j] <= dsr_in;
                end
            end
        end
    end

    assign o_quot = r_quo[N-1];

endmodule

>>> sv/epg_tstep.sv
// One Taylor series step: term' = (term * x^2 >> 30) / DIV, sum +/- term'.
// Two register stages; the divide is a reciprocal multiply. Uses no package.
module epg_tstep #(
    parameter int DIV = 2,
    parameter bit SUB = 1'b1
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [30:0]        i_term,
    input  logic [29:0]        i_x2,
    input  logic signed [31:0] i_sum,
    output logic [30:0]        o_term,
    output logic [29:0]        o_x2,
    output logic signed [31:0] o_sum
);
    // exact floor(n / DIV) for any 30-bit n
    localparam int          K   = 30 + $clog2(DIV);
    localparam logic [63:0] REC = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);

    logic [29:0]        r_n;
    logic [29:0]        r_x2a;
    logic signed [31:0] r_sum1;
    logic [60:0]        r_prod;
    logic [29:0]        r_x2b;
    logic signed [31:0] r_sum2;
    logic [60:0]        n_prod1;
    logic [29:0]        w_q;

    assign n_prod1 = 61'(i_term) * 61'(i_x2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= n_prod1[59:30];
            r_x2a  <= i_x2;
            r_sum1 <= i_sum;
            r_prod <= 61'(r_n) * 61'(REC[30:0]);
            r_x2b  <= r_x2a;
            r_sum2 <= r_sum1;
        end
    end

    // quotient is below 2^30; K + 30 can run past the product width
    assign w_q    = 30'(r_prod >> K);
    assign o_term = {1'b0, w_q};
    assign o_x2   = r_x2b;
    assign o_sum  = SUB ? r_sum2 - 32'(w_q) : r_sum2 + 32'(w_q);

endmodule

>>> sv/epg_sincos.sv
// Pipelined sine/cosine of a phase in Q0.32 turns, results in Q2.30.
// Octant reduction, then two Taylor chains of epg_tstep; uses epg_pkg.
module epg_sincos #(
    parameter int PHASE_FRAC_BITS = epg_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    localparam int          DROP    = 32 - PHASE_FRAC_BITS;
    localparam logic [31:0] PH_HALF = 32'd1 << (DROP - 1);
    localparam logic [31:0] PH_MASK = ~((32'd1 << DROP) - 32'd1);
    localparam int          QD      = epg_pkg::SC_LAT - 2;
    localparam int          NC      = epg_pkg::COS_STEPS;
    localparam int          NS      = epg_pkg::SIN_STEPS;

    logic [31:0]        n_pr;
    logic [29:0]        n_u;
    logic [29:0]        n_w;
    logic [62:0]        n_xw;
    logic [59:0]        n_xx;
    logic [29:0]        r_w;
    epg_pkg::t_sc_ctl   r_ctl_a;
    epg_pkg::t_sc_ctl   r_qd [QD];
    logic [29:0]        r_x;
    logic [29:0]        r_x2;
    logic [29:0]        r_xs;
    logic signed [31:0] r_sd1;
    logic signed [31:0] r_sd2;
    logic signed [31:0] sv;
    logic signed [31:0] cv;

    logic [30:0]        c_term [NC+1];
    logic [29:0]        c_x2   [NC+1];
    logic signed [31:0] c_sum  [NC+1];
    logic [30:0]        s_term [NS+1];
    logic [29:0]        s_x2   [NS+1];
    logic signed [31:0] s_sum  [NS+1];

    // round to the phase grid, fold into the first eighth of a turn
    assign n_pr = (i_phase + PH_HALF) & PH_MASK;
    assign n_u  = n_pr[29:0];
    assign n_w  = n_u[29] ? 30'(31'h4000_0000 - {1'b0, n_u}) : n_u;
    assign n_xw = 63'(r_w) * 63'(epg_pkg::HALF_PI_Q32);
    assign n_xx = 60'(r_x) * 60'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w     <= n_w;
            r_ctl_a <= '{quad: n_pr[31:30], swap: n_u[29]};
            r_x     <= n_xw[61:32];
            r_x2    <= n_xx[59:30];
            r_xs    <= r_x;
            r_qd[0] <= r_ctl_a;
            for (int k = 1; k < QD; k++) begin
                r_qd[k] <= r_qd[k-1];
            end
            r_sd1 <= s_sum[NS];
            r_sd2 <= r_sd1;
        end
    end

    assign c_term[0] = 31'h4000_0000;
    assign c_x2[0]   = r_x2;
    assign c_sum[0]  = 32'sh4000_0000;
    assign s_term[0] = {1'b0, r_xs};
    assign s_x2[0]   = r_x2;
    assign s_sum[0]  = $signed({2'b00, r_xs});

    for (genvar k = 0; k < NC; k++) begin : g_cos
        epg_tstep #(
            .DIV ((2 * k + 1) * (2 * k + 2)),
            .SUB ((k % 2) == 0)
        ) u_step (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_term (c_term[k]),
            .i_x2   (c_x2[k]),
            .i_sum  (c_sum[k]),
            .o_term (c_term[k+1]),
            .o_x2   (c_x2[k+1]),
            .o_sum  (c_sum[k+1])
        );
    end

    for (genvar k = 0; k < NS; k++) begin : g_sin
        epg_tstep #(
            .DIV ((2 * k + 2) * (2 * k + 3)),
            .SUB ((k % 2) == 0)
        ) u_step (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_term (s_term[k]),
            .i_x2   (s_x2[k]),
            .i_sum  (s_sum[k]),
            .o_term (s_term[k+1]),
            .o_x2   (s_x2[k+1]),
            .o_sum  (s_sum[k+1])
        );
    end

    // upper half of the quadrant uses the complementary angle
    assign sv = r_qd[QD-1].swap ? c_sum[NC] : r_sd2;
    assign cv = r_qd[QD-1].swap ? r_sd2 : c_sum[NC];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_qd[QD-1].quad)
                2'd0: begin
                    o_sin <= sv;
                    o_cos <= cv;
                end
                2'd1: begin
                    o_sin <= cv;
                    o_cos <= -sv;
                end
                2'd2: begin
                    o_sin <= -sv;
                    o_cos <= -cv;
                end
                default: begin
                    o_sin <= -cv;
                    o_cos <= sv;
                end
            endcase
        end
    end

endmodule

>>> sv/epicycloid_point_generator.sv
// Epicycloid point generator top level: config registers, ratio divider,
// two sin/cos pipelines and the coordinate combine. Uses epg_pkg and epg_* modules.
//
//  channel   direction  handshake                  payload (low bit first)
//  s         in         i_s_tvalid / o_s_tready    tdata: angle_turns[31:0]
//  m         out        o_m_tvalid / i_m_tready    tdata: point_x[19:0], point_y[19:0]
//                                                  tuser: config_error
//  cfg       in         i_cfg_wr_en                index 0 radius_big, 1 radius_small
//
// One request per cycle sustained while the output is not stalled; from accept to o_m_tvalid
// an item passes the 33-stage ratio divider and the 20-stage sin/cos pipelines.
// Synchronous active-low reset clears valid bits and reloads the radii (512, 256).
// The whole pipeline moves only while the output register is empty or being taken;
// a stall freezes every stage.
module epicycloid_point_generator #(
    parameter int COORD_FRAC_BITS = epg_pkg::COORD_FRAC_BITS_DEF,
    parameter int PHASE_FRAC_BITS = epg_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [epg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [epg_pkg::RADIUS_W-1:0]    i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [31:0]                     i_s_tdata,   // angle_turns[31:0]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [39:0]                     o_m_tdata,   // point_x[19:0], point_y[39:20]
    output logic [0:0]                      o_m_tuser    // config_error
);
    localparam int RW    = epg_pkg::RADIUS_W;
    localparam int CW    = epg_pkg::COORD_W;
    localparam int K_MUL = epg_pkg::DIV_STAGES;
    localparam int K_PRD = K_MUL + 1 + epg_pkg::SC_LAT;
    localparam int N_DLY = K_PRD + 2;
    localparam int SH    = 38 - COORD_FRAC_BITS;

    logic [RW-1:0]          r_radius_big;
    logic [RW-1:0]          r_radius_small;
    logic                   adv;
    logic [RW:0]            n_sum;
    logic [epg_pkg::DVD_W-1:0] n_dvd;
    logic [epg_pkg::DVD_W-1:0] r_dvd;
    logic                   r_vld  [N_DLY];
    epg_pkg::t_item         r_item [N_DLY];
    logic [31:0]            w_quot;
    logic [63:0]            n_p2;
    logic [31:0]            r_p1;
    logic [31:0]            r_p2;
    logic signed [31:0]     w_s1;
    logic signed [31:0]     w_c1;
    logic signed [31:0]     w_s2;
    logic signed [31:0]     w_c2;
    logic signed [49:0]     r_xa;
    logic signed [49:0]     r_xb;
    logic signed [49:0]     r_ya;
    logic signed [49:0]     r_yb;
    logic signed [50:0]     n_xv;
    logic signed [50:0]     n_yv;
    logic                   r_out_valid;
    logic [CW-1:0]          r_out_x;
    logic [CW-1:0]          r_out_y;
    logic                   r_out_err;

    function automatic logic [CW-1:0] to_coord(input logic signed [50:0] v);
        logic        neg;
        logic [50:0] mag;
        logic [51:0] rnd;
        logic [51:0] q;
        neg = v[50];
        mag = neg ? 51'(-v) : 51'(v);
        rnd = 52'(mag) + (52'd1 << (SH - 1));
        q   = rnd >> SH;
        if (!neg) begin
            return (q > 52'(epg_pkg::OUT_MAX)) ? epg_pkg::OUT_MAX : q[CW-1:0];
        end
        return (q > 52'(epg_pkg::OUT_MIN)) ? epg_pkg::OUT_MIN : CW'(0) - q[CW-1:0];
    endfunction

    assign adv        = !r_out_valid || i_m_tready;
    // no request is taken while reset is held
    assign o_s_tready = adv && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_big   <= epg_pkg::RADIUS_BIG_RST;
            r_radius_small <= epg_pkg::RADIUS_SMALL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                epg_pkg::REG_RADIUS_BIG:   r_radius_big   <= i_cfg_data;
                epg_pkg::REG_RADIUS_SMALL: r_radius_small <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_sum = (RW + 1)'(r_radius_big) + (RW + 1)'(r_radius_small);
    assign n_dvd = {n_sum, {epg_pkg::RATIO_FRAC{1'b0}}}
                 + epg_pkg::DVD_W'(r_radius_small >> 1);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_DLY; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < N_DLY; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[N_DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_item[0].angle  <= i_s_tdata;
            r_item[0].rsum   <= n_sum;
            r_item[0].rsmall <= r_radius_small;
            r_item[0].err    <= (r_radius_small == '0) || (r_radius_big <= r_radius_small);
            r_dvd            <= n_dvd;
            for (int k = 1; k < N_DLY; k++) begin
                r_item[k] <= r_item[k-1];
            end
        end
    end

    epg_ratio_div u_div (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (r_dvd),
        .i_divisor  (r_item[0].rsmall),
        .o_quot     (w_quot)
    );

    // low 32 bits of t*q: the phase of q*t wrapped to one turn
    assign n_p2 = 64'(r_item[K_MUL].angle) * 64'(w_quot);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1 <= {r_item[K_MUL].angle[15:0], 16'h0000};
            r_p2 <= n_p2[31:0];
        end
    end

    epg_sincos #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_sc1 (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_p1),
        .o_sin   (w_s1),
        .o_cos   (w_c1)
    );

    epg_sincos #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_sc2 (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_p2),
        .o_sin   (w_s2),
        .o_cos   (w_c2)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xa <= 50'($signed({1'b0, r_item[K_PRD].rsum}))   * 50'(w_c1);
            r_xb <= 50'($signed({2'b00, r_item[K_PRD].rsmall})) * 50'(w_c2);
            r_ya <= 50'($signed({1'b0, r_item[K_PRD].rsum}))   * 50'(w_s1);
            r_yb <= 50'($signed({2'b00, r_item[K_PRD].rsmall})) * 50'(w_s2);
        end
    end

    assign n_xv = 51'(r_xa) - 51'(r_xb);
    assign n_yv = 51'(r_ya) - 51'(r_yb);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_err <= r_item[N_DLY-1].err;
            r_out_x   <= r_item[N_DLY-1].err ? '0 : to_coord(n_xv);
            r_out_y   <= r_item[N_DLY-1].err ? '0 : to_coord(n_yv);
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {r_out_y, r_out_x};
    assign o_m_tuser[0] = r_out_err;

`ifndef SYNTHESIS
    // an invalid-radius result carries zero coordinates
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("error result with nonzero coordinates");

    // no request taken while the output is stalled
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted during output stall");

    // a new result comes only from the last pipeline stage
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_vld[N_DLY-1]))
        else $error("output valid without a pipeline item");

    // a frozen pipeline keeps its entry stage
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_vld[0] == $past(r_vld[0])))
        else $error("entry stage moved during stall");
`endif

endmodule

>>> bench/epicycloid_point_generator_test.sv
// Self-checking bench for epicycloid_point_generator: a fixed-point point predictor,
// a queued stream driver and a result monitor. Depends on epg_pkg and the RTL.
module epicycloid_point_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [epg_pkg::COORD_W-1:0] x;
        logic [epg_pkg::COORD_W-1:0] y;
        logic                        err;
    } t_point;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [epg_pkg::CFG_IDX_W-1:0] i_cfg_index = epg_pkg::REG_RADIUS_BIG;
    logic [epg_pkg::RADIUS_W-1:0]  i_cfg_data = '0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [31:0]                   i_s_tdata = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [39:0]                   o_m_tdata;
    logic [0:0]                    o_m_tuser;

    epicycloid_point_generator uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [31:0]                  angle_queue[$];
    t_point                       point_queue[$];
    logic [epg_pkg::RADIUS_W-1:0] big_r = epg_pkg::RADIUS_BIG_RST;
    logic [epg_pkg::RADIUS_W-1:0] small_r = epg_pkg::RADIUS_SMALL_RST;
    int unsigned                  send_idle_pct = 0;
    int unsigned                  recv_idle_pct = 0;
    int unsigned                  mismatches = 0;
    int unsigned                  quiet_cycles = 0;

    function automatic longint taylor_q30(logic [63:0] x, int first_pow);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] p;
        bit          minus;
        x2 = (x * x) >> 30;
        term = first_pow ? x : 64'd1 << 30;
        sum = longint'(term);
        p = 64'(first_pow);
        minus = 1'b1;
        while (p < 15) begin
            term = ((term * x2) >> 30) / ((p + 1) * (p + 2));
            p += 2;
            if (minus) sum -= longint'(term);
            else sum += longint'(term);
            minus = !minus;
        end
        return sum;
    endfunction

    function automatic void sincos_turns(logic [31:0] phase, output longint s,
                                         output longint c);
        logic [63:0] u;
        logic [63:0] x;
        longint      sv, cv;
        u = {34'd0, phase[29:0]};
        if (u < (64'd1 << 29)) begin
            x = (u * {31'd0, epg_pkg::HALF_PI_Q32}) >> 32;
            sv = taylor_q30(x, 1);
            cv = taylor_q30(x, 0);
        end else begin
            x = (((64'd1 << 30) - u) * {31'd0, epg_pkg::HALF_PI_Q32}) >> 32;
            sv = taylor_q30(x, 0);
            cv = taylor_q30(x, 1);
        end
        case (phase[31:30])
            2'd0: begin s = sv; c = cv; end
            2'd1: begin s = cv; c = -sv; end
            2'd2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endfunction

    // Q38 -> Q.8, half away from zero, saturated to 20 bits
    function automatic logic [epg_pkg::COORD_W-1:0] round_coord(longint v);
        bit          neg;
        logic [63:0] mag;
        longint      r;
        neg = v < 0;
        mag = neg ? -v : v;
        mag = (mag + (64'd1 << 29)) >> 30;
        if (mag > (64'd1 << 20)) mag = 64'd1 << 20;
        r = neg ? -longint'(mag) : longint'(mag);
        if (r > 524287) r = 524287;
        if (r < -524288) r = -524288;
        return r[epg_pkg::COORD_W-1:0];
    endfunction

    function automatic t_point epicycloid_point(logic [31:0] angle);
        t_point      pt;
        logic [63:0] sum, q, t, prod;
        logic [31:0] p1, p2;
        longint      s1, c1, s2, c2;
        pt = '0;
        if (big_r == 0 || small_r == 0 || big_r <= small_r) begin
            pt.err = 1'b1;
            return pt;
        end
        sum = 64'(big_r) + 64'(small_r);
        q = ((sum << epg_pkg::RATIO_FRAC) + 64'(small_r >> 1)) / 64'(small_r);
        t = {{32{angle[31]}}, angle};
        prod = t * q;
        p1 = ({angle[15:0], 16'd0} + 32'h8000) & 32'hFFFF_0000;
        p2 = (prod[31:0] + 32'h8000) & 32'hFFFF_0000;
        sincos_turns(p1, s1, c1);
        sincos_turns(p2, s2, c2);
        pt.x = round_coord(longint'(sum) * c1 - longint'(small_r) * c2);
        pt.y = round_coord(longint'(sum) * s1 - longint'(small_r) * s2);
        return pt;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_s_tvalid || o_s_tready) begin
            if (angle_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= angle_queue.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            point_queue.push_back(epicycloid_point(i_s_tdata));
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (point_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_m_tdata);
            end else begin
                want = point_queue.pop_front();
                if (o_m_tdata[19:0] !== want.x || o_m_tdata[39:20] !== want.y ||
                    o_m_tuser[0] !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("R=%0d r=%0d exp x=%h y=%h e=%b got x=%h y=%h e=%b",
                                 big_r, small_r, want.x, want.y, want.err,
                                 o_m_tdata[19:0], o_m_tdata[39:20], o_m_tuser[0]);
                end
            end
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic drain();
        while (angle_queue.size() || point_queue.size() || i_s_tvalid) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic write_radii(logic [epg_pkg::RADIUS_W-1:0] rb,
                               logic [epg_pkg::RADIUS_W-1:0] rs);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= epg_pkg::REG_RADIUS_BIG;
        i_cfg_data <= rb;
        @(posedge i_clk);
        i_cfg_index <= epg_pkg::REG_RADIUS_SMALL;
        i_cfg_data <= rs;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        big_r = rb;
        small_r = rs;
    endtask

    logic [epg_pkg::RADIUS_W-1:0] cfg_big[10] = '{16'd512, 16'd65535, 16'd65535, 16'd0,
                                                  16'd256, 16'd100, 16'd768, 16'd1,
                                                  16'd40000, 16'd300};
    logic [epg_pkg::RADIUS_W-1:0] cfg_small[10] = '{16'd256, 16'd1, 16'd65534, 16'd256,
                                                    16'd256, 16'd200, 16'd256, 16'd0,
                                                    16'd12345, 16'd7};

    initial begin
        int          phase;
        logic [31:0] a;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (phase = 0; phase < 10; phase++) begin
            if (phase < 3) begin send_idle_pct = 13; recv_idle_pct = 53; end
            else if (phase < 6) begin send_idle_pct = 53; recv_idle_pct = 13; end
            else begin send_idle_pct = 0; recv_idle_pct = 0; end
            drain();
            if (phase == 9)
                write_radii(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 2000)));
            else
                write_radii(cfg_big[phase], cfg_small[phase]);
            if (phase == 0) begin
                // field extremes, quadrant and octant edges, wrap of large angles
                angle_queue = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h2000, 32'h1FFF, 32'h4000, 32'h8000, 32'hC000,
                                32'h10000, 32'h0000_7FFF, 32'h0000_8000, 32'h6000,
                                32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000};
            end
            repeat (85) begin
                case ($urandom_range(3))
                    0: a = $urandom;
                    1: a = $urandom_range(0, 32'h1FFFF) - 32'h10000;
                    2: a = {16'd0, 2'($urandom_range(0, 3)), 14'd0}
                           + $urandom_range(0, 3) - 32'd2;
                    default: a = {16'($urandom_range(0, 65535)), 16'd0}
                                 | $urandom_range(0, 1);
                endcase
                angle_queue.push_back(a);
            end
        end
        while (angle_queue.size() || point_queue.size() || i_s_tvalid) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (mismatches == 0 && point_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
